// ----- sv/epit_pkg.sv -----
// Package for the event pair interval tally: field widths, tally geometry,
// and the structs passed between the front end and the tally stage.
// No dependencies.
`default_nettype none

package epit_pkg;

	localparam int TYPE_W      = 4;
	localparam int STAMP_W     = 32;
	localparam int COUNT_W     = 32;
	localparam int CODE_W      = 8;
	localparam int NUM_END_W   = 5;
	localparam int TALLY_DEPTH = 256;

	localparam int IN_USER_W   = 16;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_USER_W  = 8;
	localparam int OUT_DATA_W  = 64;

	localparam logic [NUM_END_W-1:0] NUM_END_RESET = NUM_END_W'(16);

	localparam int DEF_MAX_START_TYPES = 16;
	localparam int DEF_MAX_END_TYPES   = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [STAMP_W-1:0] interval;
	} tally_req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [CODE_W-1:0]  code;
		logic [STAMP_W-1:0] interval;
	} tally_res_t;

endpackage

`default_nettype wire

// ----- sv/epit_tally.sv -----
// Pair tally stage: 256 x 32 count memory with read-modify-write, a registered
// read, forwarding, per-entry valid bits and the output register.
// Depends on epit_pkg.
`default_nettype none

module epit_tally (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_vld,
	input  wire epit_pkg::tally_req_t req,
	output logic                     req_ready,
	output logic                     out_vld,
	input  wire logic                out_ready,
	output epit_pkg::tally_res_t     res
);
	import epit_pkg::*;

	localparam int AddrW = $clog2(TALLY_DEPTH);

	logic [COUNT_W-1:0] tally_mem [TALLY_DEPTH];
	logic [TALLY_DEPTH-1:0] tally_vld_q;

	logic               s1_vld_s1;
	logic [CODE_W-1:0]  s1_code_s1;
	logic [STAMP_W-1:0] s1_interval_s1;
	logic               s1_fwd_s1;
	logic [COUNT_W-1:0] s1_fwd_cnt_s1;
	logic [COUNT_W-1:0] rdata_s1;
	logic               rd_vld_s1;

	logic               out_vld_q;
	tally_res_t         res_q;

	logic               s1_adv;
	logic [COUNT_W-1:0] old_cnt;
	logic [COUNT_W-1:0] new_cnt;

	assign s1_adv    = s1_vld_s1 & (~out_vld_q | out_ready);
	assign req_ready = ~s1_vld_s1 | s1_adv;

	// old count: forwarded from the previous write, else memory, else zero
	always_comb begin
		if (s1_fwd_s1) begin
			old_cnt = s1_fwd_cnt_s1;
		end else if (rd_vld_s1) begin
			old_cnt = rdata_s1;
		end else begin
			old_cnt = '0;
		end
		new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			tally_mem[s1_code_s1[AddrW-1:0]] <= new_cnt;
		end
		if (req_vld) begin
			rdata_s1 <= tally_mem[req.code[AddrW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (req_vld) begin
			rd_vld_s1      <= tally_vld_q[req.code[AddrW-1:0]];
			s1_code_s1     <= req.code;
			s1_interval_s1 <= req.interval;
			s1_fwd_s1      <= s1_adv & (s1_code_s1 == req.code);
			s1_fwd_cnt_s1  <= new_cnt;
		end
		if (s1_adv) begin
			res_q.count    <= new_cnt;
			res_q.code     <= s1_code_s1;
			res_q.interval <= s1_interval_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_vld_q <= '0;
			s1_vld_s1   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (s1_adv) begin
				tally_vld_q[s1_code_s1[AddrW-1:0]] <= 1'b1;
			end
			if (req_vld) begin
				s1_vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				s1_vld_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_vld = out_vld_q;
	assign res     = res_q;

	a_req_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_vld |-> req_ready)
		else $error("tally request issued while stage busy");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_s1 && !s1_adv) |=> (s1_vld_s1 && $stable(s1_code_s1)))
		else $error("stalled tally entry lost");

	a_fwd_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(req_vld && s1_adv && req.code == s1_code_s1) |=> s1_fwd_s1)
		else $error("back-to-back same pair not forwarded");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (res_q.count != '0))
		else $error("emitted pair count is zero");

endmodule

`default_nettype wire

// ----- sv/event_pair_interval_tally.sv -----
// Top level of the event pair interval tally: arming front end, stride
// register and the stream ports. Depends on epit_pkg and epit_tally.
//
//   channel   dir  signals                         payload
//   s_axis    in   tvalid/tready/tdata/tuser       one classified event
//   m_axis    out  tvalid/tready/tdata/tuser       interval, pair code, count
//   cfg       in   cfg_valid/cfg_ready/cfg_data    num_end_types, always ready
//
// One event per cycle sustained unless m_axis stalls. A result passes the
// tally memory read register, then the increment into the output register,
// before it appears on m_axis. Back-to-back hits on the same pair are
// forwarded around the memory. Reset clears arming state and the tally valid
// bits and sets the stride to 16 at once (no clearing pass). s_axis_tready
// drops only while a result waits in the tally stage and the output register is stalled.
`default_nettype none

module event_pair_interval_tally #(
	parameter int MAX_START_TYPES = epit_pkg::DEF_MAX_START_TYPES,
	parameter int MAX_END_TYPES   = epit_pkg::DEF_MAX_END_TYPES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// stamp[31:0]
	input  wire logic [epit_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// is_start[0], start_type[4:1], is_end[5], end_type[9:6], is_break[10], zero pad
	input  wire logic [epit_pkg::IN_USER_W-1:0]    s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// interval[31:0], pair_count[63:32]
	output logic [epit_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	// pair_code[7:0]
	output logic [epit_pkg::OUT_USER_W-1:0]        m_axis_tuser,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [epit_pkg::NUM_END_W-1:0]    cfg_data
);
	import epit_pkg::*;

	// stride never exceeds MAX_END_TYPES
	localparam int StrideW = $clog2(MAX_END_TYPES + 1);
	localparam int MulW    = TYPE_W + StrideW + 1;

	// num_end_types of 0 acts as 1, values above the limit act as the limit
	function automatic logic [StrideW-1:0] clamp_stride(input logic [NUM_END_W-1:0] n);
		logic [StrideW-1:0] s;
		if (n == '0) begin
			s = StrideW'(1);
		end else if (int'(n) > MAX_END_TYPES) begin
			s = StrideW'(MAX_END_TYPES);
		end else begin
			s = StrideW'(n);
		end
		return s;
	endfunction

	logic [StrideW-1:0] stride_q;
	logic               armed_q;
	logic [TYPE_W-1:0]  held_type_q;
	logic [STAMP_W-1:0] held_stamp_q;

	logic               ev_is_start;
	logic [TYPE_W-1:0]  ev_start_type;
	logic               ev_is_end;
	logic [TYPE_W-1:0]  ev_end_type;
	logic               ev_is_break;
	logic [STAMP_W-1:0] ev_stamp;

	logic               s_take;
	logic               start_ok;
	logic               end_ok;
	logic [MulW-1:0]    code_full;
	logic               req_vld;
	logic               req_ready;
	tally_req_t         req;
	logic               out_vld;
	tally_res_t         res;

	assign ev_is_start   = s_axis_tuser[0];
	assign ev_start_type = s_axis_tuser[4:1];
	assign ev_is_end     = s_axis_tuser[5];
	assign ev_end_type   = s_axis_tuser[9:6];
	assign ev_is_break   = s_axis_tuser[10];
	assign ev_stamp      = s_axis_tdata[STAMP_W-1:0];

	assign s_take    = s_axis_tvalid & s_axis_tready;
	assign cfg_ready = 1'b1;

	// type indexes outside their ranges do not count as start or end
	assign start_ok = ev_is_start & (int'(ev_start_type) < MAX_START_TYPES);
	assign end_ok   = ev_is_end & (int'(ev_end_type) < int'(stride_q));

	// pair code = held start type * stride + end type, kept to 8 bits
	assign code_full = MulW'(held_type_q) * MulW'(stride_q) + MulW'(ev_end_type);

	assign req_vld      = s_take & armed_q & end_ok;
	assign req.code     = CODE_W'(code_full);
	assign req.interval = ev_stamp - held_stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q     <= clamp_stride(NUM_END_RESET);
			armed_q      <= 1'b0;
			held_type_q  <= '0;
			held_stamp_q <= '0;
		end else begin
			if (cfg_valid) begin
				stride_q <= clamp_stride(cfg_data);
			end
			if (s_take) begin
				// while armed: end closes, start re-arms, break cancels last.
				// while idle only a start matters, break or not.
				if (start_ok) begin
					held_type_q  <= ev_start_type;
					held_stamp_q <= ev_stamp;
				end
				if (!armed_q) begin
					armed_q <= start_ok;
				end else begin
					armed_q <= ((armed_q & ~end_ok) | start_ok) & ~ev_is_break;
				end
			end
		end
	end

	epit_tally u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_vld   (req_vld),
		.req       (req),
		.req_ready (req_ready),
		.out_vld   (out_vld),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	assign s_axis_tready = req_ready;
	assign m_axis_tvalid = out_vld;
	assign m_axis_tdata  = {res.count, res.interval};
	assign m_axis_tuser  = res.code;

endmodule

`default_nettype wire

// ----- dv/tb_event_pair_interval_tally.sv -----
// Self-checking bench for event_pair_interval_tally: directed event table plus
// random start/end sequences over several stride settings, checked by an
// in-bench pairing predictor. Depends on epit_pkg and the top-level RTL only.
`default_nettype none

module tb_event_pair_interval_tally;
	timeunit 1ns;
	timeprecision 1ps;

	import epit_pkg::*;

	localparam int START_LIMIT = DEF_MAX_START_TYPES;
	localparam int END_LIMIT   = DEF_MAX_END_TYPES;
	localparam int PHASE_ITEMS = 120;
	// Stride per random phase: reset value, floor, zero (clamped up), all ones
	// (clamped down), just above range, and a few in between.
	localparam logic [NUM_END_W-1:0] PHASE_STRIDE [10] =
		'{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd2, 5'd16, 5'd9, 5'd15};

	// Event flags in s_axis_tuser order, lowest bit last
	typedef struct packed {
		logic             is_break;
		logic [TYPE_W-1:0] end_type;
		logic             is_end;
		logic [TYPE_W-1:0] start_type;
		logic             is_start;
	} ev_tag_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		ev_tag_t            tag;
	} ev_t;

	typedef enum {ROW_EVENT, ROW_STRIDE} row_kind_t;
	// PIN_NONE: predictor decides; PIN_QUIET: typed as no result;
	// PIN_RESULT: typed result
	typedef enum {PIN_NONE, PIN_QUIET, PIN_RESULT} pin_t;

	typedef struct {
		pin_t       kind;
		tally_res_t res;
	} pin_note_t;

	typedef struct {
		row_kind_t           kind;
		ev_t                 ev;
		logic [NUM_END_W-1:0] stride;
		pin_note_t           note;
	} plan_row_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [NUM_END_W-1:0]  cfg_data      = '0;

	event_pair_interval_tally u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		// stamp[31:0]
		.s_axis_tdata  (s_axis_tdata),
		// is_start, start_type[3:0], is_end, end_type[3:0], is_break, zero pad
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// interval[31:0], pair_count[63:32]
		.m_axis_tdata  (m_axis_tdata),
		// pair_code[7:0]
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state: pending start and per-pair hit counts, as after reset
	logic                 pend_armed = 1'b0;
	logic [TYPE_W-1:0]    pend_type  = '0;
	logic [STAMP_W-1:0]   pend_stamp = '0;
	logic [COUNT_W-1:0]   pair_hits [TALLY_DEPTH] = '{default: '0};
	logic [NUM_END_W-1:0] end_stride = NUM_END_RESET;

	tally_res_t pair_reports_due [$]; // results owed by the block, oldest first
	pin_note_t  pinned_notes [$];     // one per event transaction still to land
	plan_row_t  plan [$];             // directed table, walked in order
	int         fault_count = 0;

	// Stimulus-side view of the stride, used only to aim end types
	int gen_span = END_LIMIT;
	logic [STAMP_W-1:0] last_stamp = '0;
	bit src_steady  = 1'b0;
	bit sink_steady = 1'b0;

	// Raw register value to the stride actually used: 0 acts as 1, clamp at max
	function automatic int span_of(input logic [NUM_END_W-1:0] v);
		if (v == 0)
			return 1;
		if (int'(v) > END_LIMIT)
			return END_LIMIT;
		return int'(v);
	endfunction

	// One event through the pairing logic; returns 1 when a report is produced.
	// While armed: close on end first, then re-arm on start, then break disarms.
	function automatic bit advance_pairing(input ev_t e, output tally_res_t rpt);
		int                span;
		bit                start_hit;
		bit                end_hit;
		bit                fired;
		logic [CODE_W-1:0] code;
		span      = span_of(end_stride);
		// start types at or above the limit are not starts; unreachable with 4-bit types
		start_hit = e.tag.is_start && (int'(e.tag.start_type) < START_LIMIT);
		end_hit   = e.tag.is_end && (int'(e.tag.end_type) < span);
		fired     = 1'b0;
		rpt       = '0;
		if (!pend_armed) begin
			// idle: break is ignored, only a start matters
			if (start_hit) begin
				pend_type  = e.tag.start_type;
				pend_stamp = e.stamp;
				pend_armed = 1'b1;
			end
		end else begin
			if (end_hit) begin
				code = CODE_W'(int'(pend_type) * span + int'(e.tag.end_type));
				// saturates at all ones; 2^32 hits on one pair is out of reach here
				if (pair_hits[code] != COUNT_MAX)
					pair_hits[code] = pair_hits[code] + 1'b1;
				rpt.interval = e.stamp - pend_stamp;
				rpt.code     = code;
				rpt.count    = pair_hits[code];
				fired        = 1'b1;
				pend_armed   = 1'b0;
			end
			if (start_hit) begin
				pend_type  = e.tag.start_type;
				pend_stamp = e.stamp;
				pend_armed = 1'b1;
			end
			if (e.tag.is_break)
				pend_armed = 1'b0;
		end
		return fired;
	endfunction

	task automatic report_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		fault_count++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
	endtask

	// Transaction monitor: inputs and outputs sampled at the edge, pre-update
	always @(posedge clk) begin : watch
		ev_t        seen;
		tally_res_t calc;
		tally_res_t want;
		pin_note_t  note;
		bit         fired;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				end_stride = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				seen.stamp = s_axis_tdata;
				seen.tag   = ev_tag_t'(s_axis_tuser[$bits(ev_tag_t)-1:0]);
				note       = pinned_notes.pop_front();
				fired      = advance_pairing(seen, calc);
				// typed rows override the predictor's view of the outcome
				if (note.kind == PIN_RESULT)
					pair_reports_due.insert(pair_reports_due.size(), note.res);
				else if (note.kind == PIN_NONE && fired)
					pair_reports_due.insert(pair_reports_due.size(), calc);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pair_reports_due.size() == 0) begin
					fault_count++;
					$display("%0t: result with none expected, interval %h code %h count %h",
						$time, m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[63:32]);
				end else begin
					want = pair_reports_due.pop_front();
					if (m_axis_tdata[31:0] !== want.interval)
						report_field("interval", want.interval, m_axis_tdata[31:0]);
					if (m_axis_tuser[CODE_W-1:0] !== want.code)
						report_field("pair_code", 32'(want.code), 32'(m_axis_tuser[CODE_W-1:0]));
					if (m_axis_tdata[63:32] !== want.count)
						report_field("pair_count", want.count, m_axis_tdata[63:32]);
				end
			end
		end
	end

	// Result sink: random stall before each transaction, with stall-free runs
	initial begin : sink
		int stall;
		forever begin
			stall = sink_steady ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if ($urandom_range(0, 15) == 0)
				sink_steady = !sink_steady;
		end
	end

	// Drive one event; tvalid stays high into the next call when no gap is drawn
	task automatic send_event(input ev_t e, input pin_note_t note);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 8);
		if ($urandom_range(0, 31) == 0)
			src_steady = !src_steady;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pinned_notes.insert(pinned_notes.size(), note);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= e.stamp;
		s_axis_tuser  <= IN_USER_W'(e.tag);
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Hold off input until every owed result is out, then let the pipe settle
	task automatic settle_quiet(input int tail);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pair_reports_due.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_stride(input logic [NUM_END_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gen_span  = span_of(v);
		@(posedge clk);
	endtask

	function automatic plan_row_t ev_row(input bit s, input logic [3:0] st, input bit en,
			input logic [3:0] et, input bit brk, input logic [31:0] stamp,
			input pin_t pin = PIN_NONE, input logic [31:0] ivl = '0,
			input logic [7:0] code = '0, input logic [31:0] cnt = '0);
		plan_row_t r;
		r.kind               = ROW_EVENT;
		r.stride             = '0;
		r.ev.stamp           = stamp;
		r.ev.tag.is_start    = s;
		r.ev.tag.start_type  = st;
		r.ev.tag.is_end      = en;
		r.ev.tag.end_type    = et;
		r.ev.tag.is_break    = brk;
		r.note.kind          = pin;
		r.note.res.interval  = ivl;
		r.note.res.code      = code;
		r.note.res.count     = cnt;
		return r;
	endfunction

	function automatic plan_row_t stride_row(input logic [NUM_END_W-1:0] v);
		plan_row_t r;
		r = ev_row(0, 0, 0, 0, 0, 0);
		r.kind   = ROW_STRIDE;
		r.stride = v;
		return r;
	endfunction

	// Append one row to the directed table
	function automatic void add_row(input plan_row_t r);
		plan.insert(plan.size(), r);
	endfunction

	// Random event; hot picks types 0..1 so the same pair repeats back to back
	function automatic ev_t make_event(input bit s, input bit en, input bit hot);
		ev_t e;
		e.tag.is_start   = s;
		e.tag.start_type = TYPE_W'(hot ? $urandom_range(0, 1) : $urandom_range(0, 15));
		e.tag.is_end     = en;
		if ($urandom_range(0, 9) == 0)
			e.tag.end_type = TYPE_W'($urandom_range(0, 15)); // may land beyond the stride
		else if (hot)
			e.tag.end_type = TYPE_W'($urandom_range(0, (gen_span > 1) ? 1 : 0));
		else
			e.tag.end_type = TYPE_W'($urandom_range(0, gen_span - 1));
		e.tag.is_break = 1'b0;
		e.stamp = ($urandom_range(0, 4) == 0) ? $urandom : last_stamp + $urandom_range(0, 5000);
		last_stamp = e.stamp;
		return e;
	endfunction

	initial begin : stimulus
		pin_note_t free_note;
		ev_t       e;
		int        sent;
		int        pick;
		int        links;
		bit        hot;

		free_note.kind = PIN_NONE;
		free_note.res  = '0;

		// Directed table, stride at reset value 16 until the first stride row.
		// start after reset, idle: arms, no result
		add_row(ev_row(1, 0, 0, 0, 0, 32'h0, PIN_QUIET));
		add_row(ev_row(0, 0, 1, 0, 0, 32'd100, PIN_RESULT, 32'd100, 8'd0, 32'd1));
		// top types, stamp wraps through zero
		add_row(ev_row(1, 15, 0, 0, 0, 32'hFFFF_FFFF));
		add_row(ev_row(0, 0, 1, 15, 0, 32'd5, PIN_RESULT, 32'd6, 8'd255, 32'd1));
		// break while idle does not stop a start from arming
		add_row(ev_row(1, 3, 0, 0, 1, 32'd10, PIN_QUIET));
		add_row(ev_row(0, 0, 1, 2, 0, 32'd30, PIN_RESULT, 32'd20, 8'd50, 32'd1));
		// end plus start closes then re-arms; end plus break closes and stays idle
		add_row(ev_row(1, 7, 0, 0, 0, 32'd1000));
		add_row(ev_row(1, 4, 1, 1, 0, 32'd1500));
		add_row(ev_row(0, 0, 1, 9, 1, 32'd1600));
		add_row(ev_row(0, 0, 1, 0, 0, 32'd1700, PIN_QUIET));
		// plain break disarms
		add_row(ev_row(1, 2, 0, 0, 0, 32'd2000));
		add_row(ev_row(0, 0, 0, 0, 1, 32'd2100, PIN_QUIET));
		add_row(ev_row(0, 0, 1, 0, 0, 32'd2200, PIN_QUIET));
		// all three flags while armed: report, re-arm, then break wins
		add_row(ev_row(1, 0, 0, 0, 0, 32'h0));
		add_row(ev_row(1, 0, 1, 0, 1, 32'd7, PIN_RESULT, 32'd7, 8'd0, 32'd2));
		add_row(ev_row(0, 0, 1, 0, 0, 32'd9, PIN_QUIET));
		// second start while armed replaces the held one
		add_row(ev_row(1, 5, 0, 0, 0, 32'd20));
		add_row(ev_row(1, 6, 0, 0, 0, 32'd25));
		add_row(ev_row(0, 0, 1, 3, 0, 32'd40));
		// zero stride acts as one; end type past the stride is not an end
		add_row(stride_row(5'd0));
		add_row(ev_row(1, 15, 0, 0, 0, 32'd50));
		add_row(ev_row(0, 0, 1, 1, 0, 32'd60, PIN_QUIET));
		add_row(ev_row(0, 0, 1, 0, 0, 32'd63, PIN_RESULT, 32'd13, 8'd15, 32'd1));
		// oversize stride clamps to 16; all-ones interval
		add_row(stride_row(5'd31));
		add_row(ev_row(1, 15, 0, 0, 0, 32'h0));
		add_row(ev_row(0, 0, 1, 15, 0, 32'hFFFF_FFFF, PIN_RESULT,
			32'hFFFF_FFFF, 8'd255, 32'd2));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_STRIDE) begin
				settle_quiet(4);
				write_stride(plan[i].stride);
			end else begin
				send_event(plan[i].ev, plan[i].note);
			end
		end

		// Random phases: mostly start/end pairs and re-arming chains, some noise
		foreach (PHASE_STRIDE[p]) begin
			settle_quiet(4);
			write_stride(PHASE_STRIDE[p]);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				hot  = ($urandom_range(0, 2) == 0);
				if (pick < 50) begin
					send_event(make_event(1'b1, 1'b0, hot), free_note);
					e = make_event($urandom_range(0, 4) == 0, 1'b1, hot);
					e.tag.is_break = ($urandom_range(0, 9) == 0);
					send_event(e, free_note);
					sent += 2;
				end else if (pick < 75) begin
					// end+start links give a report on every link whose end type is within the stride
					links = $urandom_range(1, 6);
					send_event(make_event(1'b1, 1'b0, hot), free_note);
					repeat (links)
						send_event(make_event(1'b1, 1'b1, hot), free_note);
					send_event(make_event(1'b0, 1'b1, hot), free_note);
					sent += links + 2;
				end else begin
					e.stamp = $urandom;
					e.tag   = ev_tag_t'(11'($urandom_range(0, 2047)));
					send_event(e, free_note);
					sent++;
				end
			end
		end

		settle_quiet(16);
		if (fault_count == 0)
			$display("tb_event_pair_interval_tally: done, clean");
		else
			$display("tb_event_pair_interval_tally: done, errors");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin : watchdog
		#1_000_000;
		$display("tb_event_pair_interval_tally: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
